/* hdl/cwpsnr_pkg.sv */
`default_nettype none

package cwpsnr_pkg;

   // field widths
   localparam int SAMPLE_W    = 32;
   localparam int VAR_W       = 32;
   localparam int LEN_W       = 11;
   localparam int SUM_W       = 64;
   localparam int SNR_W       = 32;

   // tdata layout: signal_real, signal_imag, noise_variance, chunk_length, zero pad
   localparam int REQ_TDATA_W = 112;
   localparam int RSP_TDATA_W = 32;

   localparam int               MAX_CHUNK_SAMPLES_DEF = 1024;
   localparam logic [LEN_W-1:0] MIN_CHUNK_RESET       = 11'd5;

   // divider and root step counter
   localparam int STEP_W = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_RE,
      ST_MUL_IM,
      ST_CHECK,
      ST_DIV,
      ST_ACC,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

/* hdl/chunked_weighted_power_snr.sv */
`default_nettype none

// Chunked weighted power SNR. Each accepted sample adds floor((re^2+im^2)*2^16/variance)
// to a 64-bit Q48.16 accumulator unless its chunk (length taken from the chunk's first
// sample, zero read as one, clamped to MAX_CHUNK_SAMPLES) is shorter than the CSR
// minimum. The sample with tlast set returns floor(sqrt(sum)) as Q24.8 in rsp_tdata and
// the saturation flag in rsp_tuser, then clears the accumulator and chunk state. After
// its req transfer, a counted sample passes through ST_MUL_RE and ST_MUL_IM on the shared
// 32x32 multiplier, a check, the bit-serial restoring divider and an accumulate before
// req_tready returns; the divider is bypassed when the variance is zero or the quotient
// saturates; a sample in a skipped chunk, unless it has tlast, leaves req_tready high. A
// tlast sample also runs the 2-bit-per-step square root and the output register handoff,
// plus any wait for the previous result to be taken. The csr channel is always ready; write it only idle.
module chunked_weighted_power_snr #(
   parameter int MAX_CHUNK_SAMPLES = cwpsnr_pkg::MAX_CHUNK_SAMPLES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [31:0] signal_real, [63:32] signal_imag, [95:64] noise_variance,
   // [106:96] chunk_length, [111:107] zero
   input  wire logic [cwpsnr_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                               req_tlast,

   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [31:0] snr
   output logic [cwpsnr_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // [0] saturated
   output logic [0:0]                              rsp_tuser,

   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cwpsnr_pkg::LEN_W-1:0]       csr_data
);

   localparam int SW    = cwpsnr_pkg::SAMPLE_W;
   localparam int VW    = cwpsnr_pkg::VAR_W;
   localparam int LW    = cwpsnr_pkg::LEN_W;
   localparam int MW    = cwpsnr_pkg::SUM_W;
   localparam int QW    = cwpsnr_pkg::SNR_W;
   localparam int TW    = cwpsnr_pkg::STEP_W;
   localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
   localparam int CMP_W = (CNT_W > LW) ? CNT_W : LW;

   cwpsnr_pkg::state_type state_ff, state_in;

   logic [LW-1:0]    min_len_ff, min_len_in;
   logic [MW-1:0]    power_sum_ff, power_sum_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             skipped_ff, skipped_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [SW-1:0]    re_mag_ff, re_mag_in;
   logic [SW-1:0]    im_mag_ff, im_mag_in;
   logic [VW-1:0]    var_ff, var_in;
   logic             last_ff, last_in;
   logic [MW-1:0]    sq_ff, sq_in;
   logic [MW-1:0]    p_ff, p_in;
   logic [VW-1:0]    rem_ff, rem_in;       // divider remainder, below the divisor while dividing
   logic [MW-1:0]    lo_ff, lo_in;         // dividend bits out, quotient bits in; root source
   logic [TW-1:0]    step_ff, step_in;
   logic [QW+1:0]    rt_rem_ff, rt_rem_in;
   logic [QW-1:0]    root_ff, root_in;
   logic [QW-1:0]    rsp_snr_ff, rsp_snr_in;
   logic             rsp_sat_ff, rsp_sat_in;

   logic             req_xfer;
   logic             rsp_load;
   logic             skip_now;

   logic [SW-1:0]    re_raw, im_raw;
   logic [LW-1:0]    len_raw, len_nz;
   logic [CMP_W-1:0] len_clamped;
   logic [SW-1:0]    mul_op;
   logic [MW-1:0]    prod;
   logic [MW-1:0]    p_sum;
   logic [VW:0]      div_trial;
   logic             div_fit;
   logic [MW:0]      acc_sum;
   logic [QW+3:0]    rt_trial_rem;
   logic [QW+3:0]    rt_trial_sub;
   logic             rt_fit;

   assign re_raw  = req_tdata[SW-1:0];
   assign im_raw  = req_tdata[2*SW-1:SW];
   assign len_raw = req_tdata[2*SW+VW+LW-1:2*SW+VW];
   assign len_nz  = (len_raw == '0) ? LW'(1) : len_raw;

   always_comb begin
      if (CMP_W'(len_nz) > CMP_W'(MAX_CHUNK_SAMPLES)) begin
         len_clamped = CMP_W'(MAX_CHUNK_SAMPLES);
      end else begin
         len_clamped = CMP_W'(len_nz);
      end
   end

   assign skip_now = (left_ff == '0) ? (len_clamped < CMP_W'(min_len_ff)) : skipped_ff;

   assign mul_op = (state_ff == cwpsnr_pkg::ST_MUL_RE) ? re_mag_ff : im_mag_ff;
   assign prod   = MW'(mul_op) * MW'(mul_op);
   assign p_sum  = p_ff + sq_ff;

   assign div_trial = {rem_ff, lo_ff[MW-1]};
   assign div_fit   = div_trial >= {1'b0, var_ff};
   assign acc_sum   = {1'b0, power_sum_ff} + {1'b0, lo_ff};

   assign rt_trial_rem = {rt_rem_ff, lo_ff[MW-1:MW-2]};
   assign rt_trial_sub = {2'b00, root_ff, 2'b01};
   assign rt_fit       = rt_trial_rem >= rt_trial_sub;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cwpsnr_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (!skip_now) begin
                  state_in = cwpsnr_pkg::ST_MUL_RE;
               end else if (req_tlast) begin
                  state_in = cwpsnr_pkg::ST_ROOT_LOAD;
               end
            end
         end
         cwpsnr_pkg::ST_MUL_RE: state_in = cwpsnr_pkg::ST_MUL_IM;
         cwpsnr_pkg::ST_MUL_IM: state_in = cwpsnr_pkg::ST_CHECK;
         cwpsnr_pkg::ST_CHECK: begin
            if (var_ff == '0 || {16'b0, p_sum[MW-1:MW-16]} >= var_ff) begin
               state_in = cwpsnr_pkg::ST_ACC;
            end else begin
               state_in = cwpsnr_pkg::ST_DIV;
            end
         end
         cwpsnr_pkg::ST_DIV: begin
            if (step_ff == '1) begin
               state_in = cwpsnr_pkg::ST_ACC;
            end
         end
         cwpsnr_pkg::ST_ACC: begin
            state_in = last_ff ? cwpsnr_pkg::ST_ROOT_LOAD : cwpsnr_pkg::ST_IDLE;
         end
         cwpsnr_pkg::ST_ROOT_LOAD: state_in = cwpsnr_pkg::ST_ROOT;
         cwpsnr_pkg::ST_ROOT: begin
            if (step_ff[TW-2:0] == '1) begin
               state_in = cwpsnr_pkg::ST_DONE;
            end
         end
         cwpsnr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = cwpsnr_pkg::ST_IDLE;
            end
         end
         default: state_in = cwpsnr_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         cwpsnr_pkg::ST_IDLE: req_tready = 1'b1;
         cwpsnr_pkg::ST_DONE: rsp_load = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
            rsp_load   = 1'b0;
         end
      endcase
   end

   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_snr_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // datapath
   always_comb begin
      min_len_in   = min_len_ff;
      power_sum_in = power_sum_ff;
      left_in      = left_ff;
      skipped_in   = skipped_ff;
      ovf_in       = ovf_ff;
      re_mag_in    = re_mag_ff;
      im_mag_in    = im_mag_ff;
      var_in       = var_ff;
      last_in      = last_ff;
      sq_in        = sq_ff;
      p_in         = p_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      step_in      = step_ff;
      rt_rem_in    = rt_rem_ff;
      root_in      = root_ff;
      rsp_snr_in   = rsp_snr_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (csr_valid && csr_ready) begin
         min_len_in = csr_data;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      case (state_ff)
         cwpsnr_pkg::ST_IDLE: begin
            if (req_xfer) begin
               re_mag_in = re_raw[SW-1] ? (~re_raw + SW'(1)) : re_raw;
               im_mag_in = im_raw[SW-1] ? (~im_raw + SW'(1)) : im_raw;
               var_in    = req_tdata[2*SW+VW-1:2*SW];
               last_in   = req_tlast;
               skipped_in = skip_now;
               if (left_ff == '0) begin
                  left_in = CNT_W'(len_clamped - CMP_W'(1));
               end else begin
                  left_in = left_ff - CNT_W'(1);
               end
            end
         end
         cwpsnr_pkg::ST_MUL_RE: sq_in = prod;
         cwpsnr_pkg::ST_MUL_IM: begin
            p_in  = sq_ff;
            sq_in = prod;
         end
         cwpsnr_pkg::ST_CHECK: begin
            step_in = '0;
            rem_in  = VW'(p_sum[MW-1:MW-16]);
            if (var_ff == '0 || {16'b0, p_sum[MW-1:MW-16]} >= var_ff) begin
               lo_in  = '1;
               ovf_in = 1'b1;
            end else begin
               lo_in = {p_sum[MW-17:0], 16'b0};
            end
         end
         cwpsnr_pkg::ST_DIV: begin
            step_in = step_ff + TW'(1);
            if (div_fit) begin
               rem_in = VW'(div_trial - {1'b0, var_ff});
            end else begin
               rem_in = div_trial[VW-1:0];
            end
            lo_in = {lo_ff[MW-2:0], div_fit};
         end
         cwpsnr_pkg::ST_ACC: begin
            if (acc_sum[MW]) begin
               power_sum_in = '1;
               ovf_in       = 1'b1;
            end else begin
               power_sum_in = acc_sum[MW-1:0];
            end
         end
         cwpsnr_pkg::ST_ROOT_LOAD: begin
            lo_in     = power_sum_ff;
            rt_rem_in = '0;
            root_in   = '0;
            step_in   = '0;
         end
         cwpsnr_pkg::ST_ROOT: begin
            step_in = step_ff + TW'(1);
            lo_in   = {lo_ff[MW-3:0], 2'b00};
            if (rt_fit) begin
               rt_rem_in = (QW+2)'(rt_trial_rem - rt_trial_sub);
            end else begin
               rt_rem_in = rt_trial_rem[QW+1:0];
            end
            root_in = {root_ff[QW-2:0], rt_fit};
         end
         cwpsnr_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_snr_in   = root_ff;
               rsp_sat_in   = ovf_ff;
               power_sum_in = '0;
               left_in      = '0;
               skipped_in   = 1'b0;
               ovf_in       = 1'b0;
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cwpsnr_pkg::ST_IDLE;
         min_len_ff   <= cwpsnr_pkg::MIN_CHUNK_RESET;
         power_sum_ff <= '0;
         left_ff      <= '0;
         skipped_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_len_ff   <= min_len_in;
         power_sum_ff <= power_sum_in;
         left_ff      <= left_in;
         skipped_ff   <= skipped_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      re_mag_ff  <= re_mag_in;
      im_mag_ff  <= im_mag_in;
      var_ff     <= var_in;
      last_ff    <= last_in;
      sq_ff      <= sq_in;
      p_ff       <= p_in;
      rem_ff     <= rem_in;
      lo_ff      <= lo_in;
      step_ff    <= step_in;
      rt_rem_ff  <= rt_rem_in;
      root_ff    <= root_in;
      rsp_snr_ff <= rsp_snr_in;
      rsp_sat_ff <= rsp_sat_in;
   end

`ifndef ASSERT_OFF
   // restoring divider keeps its remainder below the divisor
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cwpsnr_pkg::ST_DIV) |-> (rem_ff < var_ff))
      else $error("divider remainder not below divisor");

   // root remainder never exceeds twice the partial root
   a_root_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cwpsnr_pkg::ST_ROOT) |-> (rt_rem_ff <= {1'b0, root_ff, 1'b0}))
      else $error("square root remainder out of range");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cwpsnr_pkg::ST_DIV && step_ff == '1) |=> (state_ff == cwpsnr_pkg::ST_ACC))
      else $error("divider did not hand off after its last step");

   // a result handoff clears the series state
   a_clear_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && power_sum_ff == '0 && !ovf_ff && left_ff == '0))
      else $error("series state not cleared on result");

   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !skip_now) |=> !req_tready)
      else $error("input taken while a sample is being processed");
`endif

endmodule

`default_nettype wire

/* bench/tb_chunked_weighted_power_snr.sv */
`default_nettype none

module tb_chunked_weighted_power_snr;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W              = cwpsnr_pkg::SAMPLE_W;
   localparam int VAR_W                 = cwpsnr_pkg::VAR_W;
   localparam int LEN_W                 = cwpsnr_pkg::LEN_W;
   localparam int SUM_W                 = cwpsnr_pkg::SUM_W;
   localparam int SNR_W                 = cwpsnr_pkg::SNR_W;
   localparam int REQ_TDATA_W           = cwpsnr_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W           = cwpsnr_pkg::RSP_TDATA_W;
   localparam int MAX_CHUNK_SAMPLES_DEF = cwpsnr_pkg::MAX_CHUNK_SAMPLES_DEF;
   localparam logic [LEN_W-1:0] MIN_CHUNK_RESET = cwpsnr_pkg::MIN_CHUNK_RESET;

   localparam int QUIET_LIMIT = 20000;
   localparam int LONG_HOLD   = 1500;
   localparam int DRAIN_WAIT  = 120;
   localparam int PHASE_ITEMS = 195;
   localparam int MAX_SHOWN   = 10;

   typedef struct {
      logic [SAMPLE_W-1:0] re;
      logic [SAMPLE_W-1:0] im;
      logic [VAR_W-1:0]    variance;
      logic [LEN_W-1:0]    chunk_len;
      logic                last;
   } sample_type;

   typedef struct {
      logic [SNR_W-1:0] snr;
      logic             saturated;
   } snr_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tlast = 1'b0;

   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [LEN_W-1:0]       csr_data = '0;

   // stimulus and scoreboard
   sample_type     pending_samples[$];
   snr_result_type snr_expected[$];
   sample_type     cur_sample;

   // predictor state
   logic [SUM_W-1:0] power_acc;
   int               chunk_remaining;
   logic             chunk_is_skipped;
   logic             sat_seen;
   logic [LEN_W-1:0] min_len_reg;

   logic tx_idle_on = 1'b1;
   logic rx_idle_on = 1'b1;
   logic rsp_hold_go = 1'b0;

   int tx_gap_left;
   int rx_stall_left;
   int rx_hold_left;
   int quiet_cycles;
   int mismatch_count;
   int results_checked;
   int sat_results;
   int samples_sent;
   int series_sent;
   int settings_used;

   chunked_weighted_power_snr i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] magnitude(input logic [31:0] u);
      logic [31:0] neg;
      neg = ~u + 32'd1;
      return u[31] ? {32'd0, neg} : {32'd0, u};
   endfunction

   function automatic logic [31:0] root64(input logic [63:0] v);
      logic [31:0] r;
      logic [31:0] c;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         c = r | (32'd1 << i);
         if ({32'd0, c} * {32'd0, c} <= v) r = c;
      end
      return r;
   endfunction

   task automatic clear_power_state();
      power_acc        = '0;
      chunk_remaining  = 0;
      chunk_is_skipped = 1'b0;
      sat_seen         = 1'b0;
   endtask

   // one accepted sample through the accumulator; a last sample yields the SNR
   task automatic accumulate_sample(input sample_type s);
      logic [63:0]    pwr;
      logic [63:0]    term;
      logic [79:0]    quo;
      int             eff;
      snr_result_type r;
      if (chunk_remaining == 0) begin
         eff = int'(s.chunk_len);
         if (eff == 0) eff = 1;
         if (eff > MAX_CHUNK_SAMPLES_DEF) eff = MAX_CHUNK_SAMPLES_DEF;
         chunk_is_skipped = eff < int'(min_len_reg);
         chunk_remaining  = eff;
      end
      if (!chunk_is_skipped) begin
         pwr = magnitude(s.re) * magnitude(s.re) + magnitude(s.im) * magnitude(s.im);
         if (s.variance == '0) begin
            term     = '1;
            sat_seen = 1'b1;
         end else begin
            quo = {pwr, 16'h0000} / {48'd0, s.variance};
            if (quo[79:64] != '0) begin
               term     = '1;
               sat_seen = 1'b1;
            end else begin
               term = quo[63:0];
            end
         end
         if (power_acc > ~64'd0 - term) begin
            power_acc = '1;
            sat_seen  = 1'b1;
         end else begin
            power_acc = power_acc + term;
         end
      end
      chunk_remaining--;
      if (s.last) begin
         r.snr       = root64(power_acc);
         r.saturated = sat_seen;
         snr_expected.push_back(r);
         clear_power_state();
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   function automatic logic [31:0] pick_signal();
      logic [31:0] ext[4];
      logic [31:0] v;
      ext = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
      case ($urandom_range(0, 7))
         0: v = $urandom;
         1: v = $urandom_range(0, 255);
         2: v = ext[$urandom_range(0, 3)];
         3: v = $urandom_range(0, 65535);
         default: v = $urandom >> $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 1) == 1) v = ~v + 32'd1;
      return v;
   endfunction

   function automatic sample_type make_sample(input logic [LEN_W-1:0] lf, input logic last);
      sample_type  s;
      logic [63:0] p;
      int          r;
      s.re        = pick_signal();
      s.im        = pick_signal();
      s.chunk_len = lf;
      s.last      = last;
      p = magnitude(s.re) * magnitude(s.re) + magnitude(s.im) * magnitude(s.im);
      r = $urandom_range(0, 99);
      if (r < 3)       s.variance = '0;
      else if (r < 12) s.variance = $urandom_range(1, 15);
      // just above the quotient limit: terms close to 2^64
      else if (r < 20) s.variance = 32'(p >> 48) + 32'd1 + 32'($urandom_range(0, 3));
      else if (r < 35) s.variance = $urandom;
      else             s.variance = ($urandom >> $urandom_range(0, 31)) | 32'd1;
      return s;
   endfunction

   function automatic logic [LEN_W-1:0] pick_chunk_len();
      int r;
      int m;
      m = int'(min_len_reg);
      r = $urandom_range(0, 99);
      if (r < 45) return LEN_W'($urandom_range(1, 8));
      if (r < 65) return LEN_W'($urandom_range(0, 16));
      if (r < 85) return LEN_W'($urandom_range((m > 0) ? m - 1 : 0, m + 1));
      return LEN_W'($urandom_range(0, 2047));
   endfunction

   task automatic queue_sample(input logic [31:0] re, input logic [31:0] im,
                               input logic [31:0] variance, input logic [LEN_W-1:0] len,
                               input logic last);
      sample_type s;
      s.re        = re;
      s.im        = im;
      s.variance  = variance;
      s.chunk_len = len;
      s.last      = last;
      pending_samples.push_back(s);
      samples_sent++;
      if (last) series_sent++;
   endtask

   // a series of whole chunks, now and then cut short inside a chunk
   task automatic queue_random_series(output int n);
      sample_type       burst[$];
      int               nchunks;
      int               eff;
      int               take;
      logic [LEN_W-1:0] lf;
      bit               stop;
      nchunks = $urandom_range(1, 4);
      stop    = 0;
      for (int c = 0; c < nchunks && !stop; c++) begin
         lf   = pick_chunk_len();
         eff  = (lf == 0) ? 1 : ((lf > MAX_CHUNK_SAMPLES_DEF) ? MAX_CHUNK_SAMPLES_DEF : lf);
         take = eff;
         if (eff > 24) begin
            take = $urandom_range(1, 6);
            stop = 1;
         end else if (eff > 1 && $urandom_range(0, 99) < 10) begin
            take = $urandom_range(1, eff - 1);
            stop = 1;
         end
         for (int i = 0; i < take; i++)
            burst.push_back(make_sample((i == 0) ? lf : LEN_W'($urandom_range(0, 2047)), 1'b0));
      end
      burst[burst.size()-1].last = 1'b1;
      n = burst.size();
      foreach (burst[i]) pending_samples.push_back(burst[i]);
      samples_sent += n;
      series_sent++;
   endtask

   // sender stays quiet until every expected result is back, then lets the block settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || snr_expected.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_min_len(input logic [LEN_W-1:0] v);
      @(posedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid   <= 1'b0;
      min_len_reg  = v;
      settings_used++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid  <= 1'b0;
         tx_gap_left  = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            accumulate_sample(cur_sample);
            tx_gap_left = tx_idle_on ? pick_gap() : 0;
         end
         if (req_tvalid && !req_tready) begin
            // keep offering the same transfer
         end else if (tx_gap_left > 0) begin
            tx_gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            cur_sample  = pending_samples.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {5'd0, cur_sample.chunk_len, cur_sample.variance,
                           cur_sample.im, cur_sample.re};
            req_tlast  <= cur_sample.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         rx_stall_left = 0;
         rx_hold_left  = 0;
      end else if (rsp_hold_go) begin
         rx_hold_left = LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rx_idle_on && $urandom_range(0, 5) == 0) rx_stall_left = pick_gap();
      end
   end

   // monitor
   always @(posedge clock) begin
      snr_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (snr_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
               $display("unexpected result: snr=%h sat=%b", rsp_tdata, rsp_tuser[0]);
         end else begin
            e = snr_expected.pop_front();
            results_checked++;
            if (e.saturated) sat_results++;
            if (rsp_tdata !== e.snr || rsp_tuser[0] !== e.saturated) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("result %0d: expected snr=%h sat=%b, got snr=%h sat=%b",
                           results_checked, e.snr, e.saturated, rsp_tdata, rsp_tuser[0]);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, snr_expected.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      logic [LEN_W-1:0] settings[7];
      int               phase_items;
      int               n;
      settings = '{11'd5, 11'd1, 11'd3, 11'd0, 11'd0, 11'd8, 11'd1024};
      settings[4] = LEN_W'($urandom_range(0, 1024));
      min_len_reg = MIN_CHUNK_RESET;
      clear_power_state();
      mismatch_count  = 0;
      results_checked = 0;
      sat_results     = 0;
      samples_sent    = 0;
      series_sent     = 0;
      settings_used   = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset minimum of 5: counted chunk with extremes, zero variance, quotient overflow
      queue_sample(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 11'd5, 1'b0);
      queue_sample(32'h0, 32'h0, 32'h1, 11'd0, 1'b0);
      queue_sample(32'hffff_ffff, 32'h1, 32'h0, 11'd2047, 1'b0);
      queue_sample(32'h8000_0000, 32'h8000_0000, 32'h1, 11'd0, 1'b0);
      queue_sample(32'd12345, -32'sd678, 32'd1000, 11'd3, 1'b1);
      // short chunk skipped: zero variance ignored, result still sent
      queue_sample(32'd100, 32'd100, 32'h0, 11'd2, 1'b0);
      queue_sample(-32'sd5, 32'd7, 32'h0, 11'd0, 1'b1);
      // oversize length clamps; two near-2^64 terms overflow the sum
      queue_sample(32'h8000_0000, 32'h0, 32'h0000_4001, 11'd2047, 1'b0);
      queue_sample(32'h8000_0000, 32'h0, 32'h0000_4001, 11'd1, 1'b0);
      queue_sample(32'd3, 32'd4, 32'd1, 11'd1, 1'b1);
      // series ends inside a counted chunk
      queue_sample(32'd1000, 32'd2000, 32'd3, 11'd6, 1'b0);
      queue_sample(32'd1000, -32'sd2000, 32'd3, 11'd0, 1'b1);

      wait_drained();
      write_min_len(11'd0);
      // zero length counts as a one-sample chunk
      queue_sample(32'd1, 32'd0, 32'd1, 11'd0, 1'b0);
      queue_sample(32'hffff_ffff, 32'hffff_ffff, 32'd2, 11'd1, 1'b1);

      wait_drained();
      write_min_len(11'd1024);
      queue_sample(32'd77, 32'd88, 32'h0, 11'd1023, 1'b1);
      queue_sample(32'h3b9a_ca00, 32'h0, 32'd7, 11'd1024, 1'b0);
      queue_sample(32'h0, 32'h3b9a_ca00, 32'd7, 11'd5, 1'b1);

      for (int k = 0; k < 7; k++) begin
         wait_drained();
         write_min_len(settings[k]);
         tx_idle_on <= (k % 3 != 1);
         rx_idle_on <= (k % 3 != 2);
         if (k == 6) begin
            // receiver holds off while short skipped series pile up behind it
            @(posedge clock);
            rsp_hold_go <= 1'b1;
            @(posedge clock);
            rsp_hold_go <= 1'b0;
            for (int j = 0; j < 40; j++) begin
               queue_sample($urandom, $urandom, $urandom, 11'd1, 1'b0);
               queue_sample($urandom, $urandom, $urandom, 11'd1, 1'b1);
            end
         end
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            queue_random_series(n);
            phase_items += n;
         end
      end

      wait_drained();
      $display("Sent %0d samples in %0d series under %0d minimum chunk lengths;",
               samples_sent, series_sent, settings_used);
      $display("checked %0d SNR results, %0d of them saturated.",
               results_checked, sat_results);
      if (mismatch_count == 0 && snr_expected.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
